### rtl/rzt_pkg.sv
// Shared constants, register indexes and helpers for the rolling z-score block.
`default_nettype none
package rzt_pkg;

  // Default sizing
  localparam int MAX_WINDOW_DEF = 64;
  localparam int PRICE_BITS_DEF = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BULL_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BEAR_THRESHOLD = 2'd2;
  localparam int WL_FIELD_W = 7;

  // Register reset values
  localparam int          WL_RESET   = 5;
  localparam logic signed [15:0] BULL_RESET = 16'sd512;
  localparam logic signed [15:0] BEAR_RESET = -16'sd256;

  // Result formats
  localparam int Z_W    = 16;
  localparam int STAT_W = 32;
  localparam int FRAC_W = 8;
  localparam logic signed [Z_W-1:0] Z_POS_MAX = 16'sh7FFF;
  localparam logic signed [Z_W-1:0] Z_NEG_MAX = -16'sh8000;
  // Largest scale exponent for the z-score root
  localparam int K_MAX      = 8;
  localparam int K_W        = 4;
  localparam int ROOT_LIMIT = 63;

  // Trend codes
  localparam logic [1:0] TREND_NEUTRAL = 2'd0;
  localparam logic [1:0] TREND_BULL    = 2'd1;
  localparam logic [1:0] TREND_BEAR    = 2'd2;

  function automatic int maxi(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

### rtl/rzt_in_if.sv
// Input channel: one price word with its append flag.
`default_nettype none
interface rzt_in_if #(
  parameter int PRICE_BITS = rzt_pkg::PRICE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] price;
  logic                  append;

  modport source (output valid, output price, output append, input ready);
  modport sink   (input valid, input price, input append, output ready);
endinterface
`default_nettype wire

### rtl/rzt_out_if.sv
// Result channel: z-score, trend class and window statistics.
`default_nettype none
interface rzt_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rzt_pkg::Z_W-1:0]   z_score;
  logic [1:0]                       trend;
  logic [rzt_pkg::STAT_W-1:0]       window_mean;
  logic [rzt_pkg::STAT_W-1:0]       window_deviation;
  logic                             history_ready;

  modport source (output valid, output z_score, output trend, output window_mean,
                  output window_deviation, output history_ready, input ready);
  modport sink   (input valid, input z_score, input trend, input window_mean,
                  input window_deviation, input history_ready, output ready);
endinterface
`default_nettype wire

### rtl/rolling_zscore_trend.sv
// Rolling z-score and trend classifier over a ring of stored prices.
//
// Channels: in_chan takes one price word with an append flag; out_chan gives
// one result word per input word (z-score Q8.8, trend class, window mean and
// population deviation in Q24.8, history-ready flag). Both are valid/ready.
// cfg_we/cfg_index/cfg_data write window_length, bull_threshold and
// bear_threshold; a window_length write empties the history.
//
// One word is worked at a time. A word with too little history skips the
// arithmetic units. A scored word goes through the shared restoring divider
// for the mean and the variance and the shared square-root unit for the
// deviation; if the variance is not zero, a second root and a third division
// give the quotient.
// The price history sits in a single RAM; the oldest price is read at accept
// and, for an appended word, the new one written as the result is handed over.
// Reset empties the history and loads the register defaults; the RAM is not
// cleared, as no entry is used before it is written.
// A stalled receiver holds the result register; the next word is still taken
// and worked, and waits in its final state until the register frees up.
`default_nettype none
module rolling_zscore_trend #(
  parameter int MAX_WINDOW = rzt_pkg::MAX_WINDOW_DEF,
  parameter int PRICE_BITS = rzt_pkg::PRICE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rzt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rzt_pkg::CFG_DATA_W-1:0] cfg_data,
  rzt_in_if.sink                              in_chan,
  rzt_out_if.source                           out_chan
);
  import rzt_pkg::*;

  localparam int IW   = $clog2(MAX_WINDOW);
  localparam int WB   = $clog2(MAX_WINDOW + 1);
  localparam int SW   = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int QW   = 2 * PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int VW   = WB + QW;
  localparam int NW   = VW + 16;
  localparam int PW   = WB + PRICE_BITS;
  localparam int NUMW = maxi(PW, SW) + 1;
  localparam int SIN  = ((maxi(2 * PRICE_BITS + 16, VW) + 1) / 2) * 2;
  localparam int RW   = SIN / 2;
  localparam int DW   = maxi(2 * WB, RW);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL  = 9'b000000010,
    ST_DIFF = 9'b000000100,
    ST_MEAN = 9'b000001000,
    ST_VAR  = 9'b000010000,
    ST_DEV  = 9'b000100000,
    ST_ROOT = 9'b001000000,
    ST_QUOT = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [WB-1:0]         wl_r;
  logic signed [Z_W-1:0] bull_r;
  logic signed [Z_W-1:0] bear_r;
  logic [WB-1:0]         wl_c;

  // History bookkeeping
  logic [IW-1:0] wi_r;
  logic [WB-1:0] fill_r;
  logic [SW-1:0] sum_r;
  logic [QW-1:0] sq_r;

  // Per-word working registers
  logic [PRICE_BITS-1:0]   price_r;
  logic                    append_r;
  logic                    rdy_r;
  logic [PRICE_BITS-1:0]   old_r;
  logic [2*PRICE_BITS-1:0] osq_r;
  logic [2*PRICE_BITS-1:0] psq_r;
  logic [VW-1:0]           wq_r;
  logic [2*SW-1:0]         ss_r;
  logic [PW-1:0]           wp_r;
  logic [VW-1:0]           v_r;
  logic [NUMW-1:0]         mag_r;
  logic                    neg_r;
  logic [K_W-1:0]          k_r;
  logic [STAT_W-1:0]       mean_r;
  logic [STAT_W-1:0]       dev_r;
  logic signed [Z_W-1:0]   z_r;
  logic                    zlive_r;

  // Result register
  logic                    out_valid_r;
  logic signed [Z_W-1:0]   out_z_r;
  logic [1:0]              out_trend_r;
  logic [STAT_W-1:0]       out_mean_r;
  logic [STAT_W-1:0]       out_dev_r;
  logic                    out_hr_r;

  logic accept;
  logic fire;
  logic [WB:0]     old_sum;
  logic [IW-1:0]   old_idx;
  logic [NUMW-1:0] num_c;
  logic [K_W-1:0]  k_c;
  logic [2*WB-1:0] ww;
  logic [1:0]      trend_c;
  logic signed [Z_W-1:0] z_c;

  logic            div_start;
  logic [NW-1:0]   div_a;
  logic [DW-1:0]   div_b;
  logic            div_done;
  logic [NW-1:0]   div_q;
  logic            sq_start;
  logic [SIN-1:0]  sq_in;
  logic            sq_done;
  logic [RW-1:0]   sq_root;

  logic [PRICE_BITS-1:0] ram_rdata;

  assign accept = in_chan.valid && in_chan.ready;
  assign fire   = (state_r == ST_DONE) && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = (state_r == ST_IDLE);

  // Oldest window entry: (write index - window length) mod depth
  always_comb begin
    old_sum = (WB+1)'(wi_r) + (WB+1)'(MAX_WINDOW) - (WB+1)'(wl_r);
    if (old_sum >= (WB+1)'(MAX_WINDOW)) begin
      old_sum = old_sum - (WB+1)'(MAX_WINDOW);
    end
    old_idx = old_sum[IW-1:0];
  end

  // Window length clamp
  always_comb begin
    if (cfg_data[WL_FIELD_W-1:0] == '0) begin
      wl_c = WB'(1);
    end else if (32'(cfg_data[WL_FIELD_W-1:0]) > MAX_WINDOW) begin
      wl_c = WB'(MAX_WINDOW);
    end else begin
      wl_c = WB'(cfg_data[WL_FIELD_W-1:0]);
    end
  end

  // Signed distance of the price from the mean, scaled by W
  assign num_c = NUMW'(wp_r) - NUMW'(sum_r);
  assign ww    = wl_r * wl_r;

  // Largest root scale, up to K_MAX, that keeps V*4^k below 2^63
  always_comb begin
    k_c = '0;
    for (int i = 0; i <= K_MAX; i++) begin
      if ((v_r >> (ROOT_LIMIT - 2 * i)) == '0) begin
        k_c = K_W'(i);
      end
    end
  end

  // Saturated signed z-score from the divider quotient
  always_comb begin
    if (neg_r) begin
      z_c = (div_q >= NW'(32768)) ? Z_NEG_MAX : -$signed(div_q[Z_W-1:0]);
    end else begin
      z_c = (div_q > NW'(32767)) ? Z_POS_MAX : $signed(div_q[Z_W-1:0]);
    end
  end

  // Trend class
  always_comb begin
    trend_c = TREND_NEUTRAL;
    if (zlive_r) begin
      if (z_r > bull_r) begin
        trend_c = TREND_BULL;
      end else if (z_r < bear_r) begin
        trend_c = TREND_BEAR;
      end
    end
  end

  // Launches of the shared divider and root unit
  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = '0;
    sq_start  = 1'b0;
    sq_in     = '0;
    case (state_r)
      ST_DIFF: begin
        div_start = rdy_r;
        div_a     = NW'({sum_r, {FRAC_W{1'b0}}}) + NW'(wl_r >> 1);
        div_b     = DW'(wl_r);
      end
      ST_MEAN: begin
        div_start = div_done;
        div_a     = NW'({v_r, 16'h0000});
        div_b     = DW'(ww);
      end
      ST_VAR: begin
        sq_start = div_done;
        sq_in    = SIN'(div_q);
      end
      ST_DEV: begin
        sq_start = sq_done && (v_r != '0);
        sq_in    = SIN'(v_r) << {k_r, 1'b0};
      end
      ST_ROOT: begin
        div_start = sq_done;
        div_a     = NW'(mag_r) << (NW'(FRAC_W) + NW'(k_r));
        div_b     = DW'(sq_root);
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = rdy_r ? ST_MEAN : ST_DONE;
      ST_MEAN: if (div_done) state_nxt = ST_VAR;
      ST_VAR:  if (div_done) state_nxt = ST_DEV;
      ST_DEV: begin
        if (sq_done) begin
          state_nxt = (v_r != '0) ? ST_ROOT : ST_DONE;
        end
      end
      ST_ROOT: if (sq_done) state_nxt = ST_QUOT;
      ST_QUOT: if (div_done) state_nxt = ST_DONE;
      ST_DONE: if (fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          price_r  <= in_chan.price;
          append_r <= in_chan.append;
          rdy_r    <= (fill_r >= wl_r);
          z_r      <= '0;
          zlive_r  <= 1'b0;
          mean_r   <= '0;
          dev_r    <= '0;
        end
      end
      ST_MUL: begin
        wq_r  <= wl_r * sq_r;
        ss_r  <= sum_r * sum_r;
        wp_r  <= wl_r * price_r;
        psq_r <= price_r * price_r;
        old_r <= ram_rdata;
        osq_r <= ram_rdata * ram_rdata;
      end
      ST_DIFF: begin
        v_r   <= wq_r - VW'(ss_r);
        neg_r <= num_c[NUMW-1];
        mag_r <= num_c[NUMW-1] ? -num_c : num_c;
      end
      ST_MEAN: begin
        k_r <= k_c;
        if (div_done) mean_r <= div_q[STAT_W-1:0];
      end
      ST_DEV: begin
        if (sq_done) dev_r <= STAT_W'(sq_root);
      end
      ST_QUOT: begin
        if (div_done) begin
          z_r     <= z_c;
          zlive_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_z_r     <= z_r;
      out_trend_r <= trend_c;
      out_mean_r  <= mean_r;
      out_dev_r   <= dev_r;
      out_hr_r    <= rdy_r;
    end
  end

  // Control: state, history, configuration, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wl_r        <= WB'(WL_RESET);
      bull_r      <= BULL_RESET;
      bear_r      <= BEAR_RESET;
      wi_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      // Ring update as the result leaves
      if (fire && append_r) begin
        sum_r <= sum_r - (rdy_r ? SW'(old_r) : '0) + SW'(price_r);
        sq_r  <= sq_r - (rdy_r ? QW'(osq_r) : '0) + QW'(psq_r);
        wi_r  <= (wi_r == IW'(MAX_WINDOW - 1)) ? '0 : wi_r + 1'b1;
        if (fill_r < WB'(MAX_WINDOW)) fill_r <= fill_r + 1'b1;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_LENGTH: begin
            wl_r   <= wl_c;
            wi_r   <= '0;
            fill_r <= '0;
            sum_r  <= '0;
            sq_r   <= '0;
          end
          CFG_BULL_THRESHOLD: bull_r <= $signed(cfg_data[Z_W-1:0]);
          CFG_BEAR_THRESHOLD: bear_r <= $signed(cfg_data[Z_W-1:0]);
          default: begin
          end
        endcase
      end
    end
  end

  rzt_ram #(
    .WIDTH(PRICE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_hist (
    .clk    (clk),
    .wr_en  (fire && append_r),
    .wr_addr(wi_r),
    .wr_data(price_r),
    .rd_en  (accept),
    .rd_addr(old_idx),
    .rd_data(ram_rdata)
  );

  rzt_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_a),
    .divisor (div_b),
    .done    (div_done),
    .quot    (div_q)
  );

  rzt_sqrt #(
    .SIN(SIN)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .radicand(sq_in),
    .done    (sq_done),
    .root    (sq_root)
  );

  assign out_chan.valid            = out_valid_r;
  assign out_chan.z_score          = out_z_r;
  assign out_chan.trend            = out_trend_r;
  assign out_chan.window_mean      = out_mean_r;
  assign out_chan.window_deviation = out_dev_r;
  assign out_chan.history_ready    = out_hr_r;

  // Statistics are only worked for a word with a full window
  a_div_needs_history: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> rdy_r)
    else $error("divider launched without a full window");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WB'(MAX_WINDOW))
    else $error("fill count beyond ring depth");

  a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == '0 |-> (sum_r == '0 && sq_r == '0))
    else $error("sums not empty with empty history");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result shown outside the final state");

endmodule
`default_nettype wire

### rtl/rzt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rzt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

### rtl/rzt_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module rzt_div #(
  parameter int NW = 77,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quot
);
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [NW-1:0] sh_r;

  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] rem_nxt;

  // Trial subtract of the shifted remainder
  always_comb begin
    rem_sh  = {rem_r, sh_r[NW-1]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = ge ? DW'(rem_sh - {1'b0, dvs_r}) : DW'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        rem_r  <= '0;
        sh_r   <= dividend;
        dvs_r  <= divisor;
        cnt_r  <= CW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        sh_r  <= {sh_r[NW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = sh_r;
endmodule
`default_nettype wire

### rtl/rzt_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none
module rzt_sqrt #(
  parameter int SIN = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SIN-1:0]   radicand,
  output logic                  done,
  output logic [SIN/2-1:0]      root
);
  localparam int RW = SIN / 2;
  localparam int CW = $clog2(RW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [SIN-1:0] rad_r;
  logic [RW:0]   rem_r;
  logic [RW-1:0] root_r;

  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;
  logic          ge;

  // Bring down two radicand bits and try root*4+1
  always_comb begin
    rem_sh = {rem_r, rad_r[SIN-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        rad_r  <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CW'(RW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rad_r  <= {rad_r[SIN-3:0], 2'b00};
        rem_r  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
        root_r <= {root_r[RW-2:0], ge};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire
